### design/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int ARENAS          = 2;
  localparam int HEAPS_PER_ARENA = 4;
  localparam int HEAP_BYTES      = 65536;
  localparam int MAX_SEGMENTS    = 64;
  localparam int HEADER_BYTES    = 32;

  localparam int UNIT_BYTES = 32;
  localparam int UNIT_SHIFT = 5;
  localparam int HEAP_COUNT = ARENAS * HEAPS_PER_ARENA;
  localparam int HEAP_W     = $clog2(HEAP_COUNT);
  localparam int HEAP_UNITS = HEAP_BYTES / UNIT_BYTES;
  localparam int HDR_UNITS  = (HEADER_BYTES + UNIT_BYTES - 1) / UNIT_BYTES;
  localparam int MIN_KEEP   = HDR_UNITS + 1;

  localparam int START_W  = 14;
  localparam int UNITS_W  = 12;
  localparam int ADDR_W   = 19;
  localparam int REQ_W    = 16;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 8;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic CFG_ARENA_PRESENT = 1'b0;
  localparam logic CFG_CURRENT_HEAPS = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_ARENA   = 3'd1,
    ST_NOFIT   = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ASCAN,
    S_ADO,
    S_USCAN,
    S_FSCAN,
    S_FDO,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [UNITS_W-1:0] units;
  } seg_t;

  typedef struct packed {
    logic               valid;
    logic [START_W-1:0] start;
    logic [UNITS_W-1:0] units;
  } used_t;

endpackage

### design/first_fit_heap_allocator.sv
// One request at a time; each request walks the segment and used-block
// tables one entry per cycle.
// Reset: synchronous; a clearing pass sweeps every used-block table entry
// with s_tready low.
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator with coalescing free list, one free table per heap.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
  parameter int MAX_SEGMENTS = ffha_pkg::MAX_SEGMENTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // arena, heap_index, request_bytes, block_address
  input  logic        s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // result_address, status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [ffha_pkg::CFG_W-1:0] cfg_data
);

  localparam int SEG_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int HW     = ffha_pkg::HEAP_W;
  localparam int MEM_AW = HW + SEG_W;
  localparam int DEPTH  = 2 ** MEM_AW;
  localparam int AW     = ffha_pkg::ADDR_W;
  localparam int SW     = ffha_pkg::START_W;
  localparam int UW     = ffha_pkg::UNITS_W;

  ffha_pkg::state_t state, state_next;

  logic [1:0] arena_present;
  logic [7:0] current_heaps;

  logic                  cmd_q;
  logic [HW-1:0]         heap_q;
  logic [UW-1:0]         need_q;
  logic [AW-1:0]         addr_q;
  logic [CNT_W-1:0]      n_q;
  logic [CNT_W-1:0]      rd_i;
  logic                  pv;
  logic [SEG_W-1:0]      ck_i;
  logic                  slot_found;
  logic [SEG_W-1:0]      slot_q;
  logic                  hit;
  logic [CNT_W-1:0]      p_q;
  ffha_pkg::seg_t        nxt_q, prev_q;
  logic [SW-1:0]         st_q;
  logic [UW-1:0]         un_q;
  logic                  sh_dn, pend, fin_wr;
  logic [CNT_W-1:0]      sh_i, sh_lim;
  logic [SEG_W-1:0]      pend_dst;
  logic [MEM_AW-1:0]     clr_i;
  ffha_pkg::status_t     status_q, status_next;
  logic [AW-1:0]         res_q;
  logic [CNT_W-1:0]      cnt [ffha_pkg::HEAP_COUNT];
  logic [ffha_pkg::HEAP_COUNT-1:0] seg0_wr;

  ffha_pkg::seg_t free_mem [DEPTH];
  ffha_pkg::used_t used_mem [DEPTH];
  ffha_pkg::seg_t free_rd, free_eff, free_wdata;
  ffha_pkg::used_t used_rd, used_wdata;
  logic           free_z;
  logic           free_we, free_re, used_we, used_re;
  logic [SEG_W-1:0] free_waddr, free_raddr, used_raddr;
  logic [MEM_AW-1:0] used_waddr;

  // request decode
  logic          in_acc;
  logic          a_in;
  logic [2:0]    hidx_in;
  logic [2:0]    hsel;
  logic          bad_in;
  logic [HW-1:0] heap_in;
  logic [16:0]   need_sum;

  assign in_acc   = s_tvalid && s_tready;
  assign a_in     = s_tdata[0];
  assign hidx_in  = s_tdata[3:1];
  assign hsel     = hidx_in[2] ? {1'b0, (a_in ? current_heaps[3:2] : current_heaps[1:0])}
                               : hidx_in;
  assign bad_in   = (32'(a_in) >= 32'(ffha_pkg::ARENAS)) || !arena_present[a_in] ||
                    (32'(hsel) >= 32'(ffha_pkg::HEAPS_PER_ARENA));
  assign heap_in  = HW'(a_in) * HW'(ffha_pkg::HEAPS_PER_ARENA) + HW'(hsel);
  assign need_sum = {1'b0, s_tdata[19:4]} +
                    17'(ffha_pkg::HEADER_BYTES + ffha_pkg::UNIT_BYTES - 1);

  assign s_tready  = (state == ffha_pkg::S_IDLE) && !m_tvalid;
  assign cfg_ready = 1'b1;

  // datapath compares
  logic                 issue_all, issue_n, rd_go;
  logic                 u_match;
  logic [UW-1:0]        left;
  logic                 whole;
  logic                 mprev, mnext;
  logic [SW:0]          prev_end, blk_end;

  assign free_eff  = free_z ? '{start: SW'(heap_q) * SW'(ffha_pkg::HEAP_UNITS),
                                units: UW'(ffha_pkg::HEAP_UNITS)} : free_rd;
  assign issue_all = rd_i < CNT_W'(MAX_SEGMENTS);
  assign issue_n   = rd_i < n_q;
  assign rd_go     = sh_dn ? ((CNT_W+1)'(sh_i) + 1'b1 < (CNT_W+1)'(sh_lim)) : (sh_i > sh_lim);
  assign u_match   = used_rd.valid &&
                     ((AW+1)'({used_rd.start, {ffha_pkg::UNIT_SHIFT{1'b0}}}) +
                      (AW+1)'(ffha_pkg::HEADER_BYTES)) == {1'b0, addr_q};
  assign left      = nxt_q.units - need_q;
  assign whole     = nxt_q.units < need_q + UW'(ffha_pkg::MIN_KEEP);
  assign prev_end  = (SW+1)'(prev_q.start) + (SW+1)'(prev_q.units);
  assign blk_end   = (SW+1)'(st_q) + (SW+1)'(un_q);
  assign mprev     = (p_q != '0) && (prev_end == (SW+1)'(st_q));
  assign mnext     = hit && (blk_end == (SW+1)'(nxt_q.start));

  always_comb begin
    state_next  = state;
    status_next = status_q;
    free_we     = 1'b0;
    free_waddr  = '0;
    free_wdata  = free_eff;
    free_re     = 1'b0;
    free_raddr  = rd_i[SEG_W-1:0];
    used_we     = 1'b0;
    used_waddr  = {heap_q, slot_q};
    used_wdata  = '{valid: 1'b0, start: st_q, units: un_q};
    used_re     = 1'b0;
    used_raddr  = rd_i[SEG_W-1:0];
    case (state)
      ffha_pkg::S_CLEAR: begin
        used_we    = 1'b1;
        used_waddr = clr_i;
        if (clr_i == '1) state_next = ffha_pkg::S_IDLE;
      end
      ffha_pkg::S_IDLE: begin
        if (in_acc) begin
          status_next = ffha_pkg::ST_OK;
          if (bad_in) begin
            status_next = ffha_pkg::ST_ARENA;
            state_next  = ffha_pkg::S_DONE;
          end else if (s_tuser == ffha_pkg::CMD_ALLOC) begin
            state_next = ffha_pkg::S_ASCAN;
          end else begin
            state_next = ffha_pkg::S_USCAN;
          end
        end
      end
      ffha_pkg::S_ASCAN: begin
        used_re = issue_all;
        free_re = issue_all;
        if (pv && ck_i == SEG_W'(MAX_SEGMENTS - 1)) state_next = ffha_pkg::S_ADO;
      end
      ffha_pkg::S_ADO: begin
        if (!slot_found) begin
          status_next = ffha_pkg::ST_FULL;
          state_next  = ffha_pkg::S_DONE;
        end else if (!hit) begin
          status_next = ffha_pkg::ST_NOFIT;
          state_next  = ffha_pkg::S_DONE;
        end else begin
          used_we    = 1'b1;
          used_wdata = '{valid: 1'b1, start: nxt_q.start,
                         units: whole ? nxt_q.units : need_q};
          if (whole) begin
            state_next = ffha_pkg::S_SHIFT;
          end else begin
            free_we    = 1'b1;
            free_waddr = p_q[SEG_W-1:0];
            free_wdata = '{start: nxt_q.start + SW'(need_q), units: left};
            state_next = ffha_pkg::S_DONE;
          end
        end
      end
      ffha_pkg::S_USCAN: begin
        used_re = issue_all;
        if (pv && ck_i == SEG_W'(MAX_SEGMENTS - 1)) begin
          if (slot_found || u_match) begin
            state_next = ffha_pkg::S_FSCAN;
          end else begin
            status_next = ffha_pkg::ST_UNKNOWN;
            state_next  = ffha_pkg::S_DONE;
          end
        end
      end
      ffha_pkg::S_FSCAN: begin
        free_re = issue_n;
        if (!issue_n && !pv) state_next = ffha_pkg::S_FDO;
      end
      ffha_pkg::S_FDO: begin
        used_we = 1'b1;
        if (mprev && mnext) begin
          free_we    = 1'b1;
          free_waddr = SEG_W'(p_q - 1'b1);
          free_wdata = '{start: prev_q.start, units: prev_q.units + un_q + nxt_q.units};
          state_next = ffha_pkg::S_SHIFT;
        end else if (mprev) begin
          free_we    = 1'b1;
          free_waddr = SEG_W'(p_q - 1'b1);
          free_wdata = '{start: prev_q.start, units: prev_q.units + un_q};
          state_next = ffha_pkg::S_DONE;
        end else if (mnext) begin
          free_we    = 1'b1;
          free_waddr = p_q[SEG_W-1:0];
          free_wdata = '{start: st_q, units: nxt_q.units + un_q};
          state_next = ffha_pkg::S_DONE;
        end else if (n_q >= CNT_W'(MAX_SEGMENTS)) begin
          used_we     = 1'b0;
          status_next = ffha_pkg::ST_FULL;
          state_next  = ffha_pkg::S_DONE;
        end else begin
          state_next = ffha_pkg::S_SHIFT;
        end
      end
      ffha_pkg::S_SHIFT: begin
        free_re    = rd_go;
        free_raddr = sh_dn ? SEG_W'(sh_i + 1'b1) : SEG_W'(sh_i - 1'b1);
        if (pend) begin
          free_we    = 1'b1;
          free_waddr = pend_dst;
          free_wdata = free_eff;
        end else if (!rd_go) begin
          if (fin_wr) begin
            free_we    = 1'b1;
            free_waddr = p_q[SEG_W-1:0];
            free_wdata = '{start: st_q, units: un_q};
          end
          state_next = ffha_pkg::S_DONE;
        end
      end
      ffha_pkg::S_DONE: begin
        state_next = ffha_pkg::S_IDLE;
      end
      default: begin
        state_next = ffha_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ffha_pkg::S_CLEAR;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (free_we) free_mem[{heap_q, free_waddr}] <= free_wdata;
    if (free_re) begin
      free_rd <= free_mem[{heap_q, free_raddr}];
      free_z  <= (free_raddr == '0) && !seg0_wr[heap_q];
    end
  end

  always_ff @(posedge clk) begin
    if (used_we) used_mem[used_waddr] <= used_wdata;
    if (used_re) used_rd <= used_mem[{heap_q, used_raddr}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arena_present <= '0;
      current_heaps <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ffha_pkg::CFG_ARENA_PRESENT: arena_present <= cfg_data[1:0];
        ffha_pkg::CFG_CURRENT_HEAPS: current_heaps <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_i    <= '0;
      m_tvalid <= 1'b0;
      seg0_wr  <= '0;
      pv       <= 1'b0;
      pend     <= 1'b0;
      status_q <= ffha_pkg::ST_OK;
      for (int h = 0; h < ffha_pkg::HEAP_COUNT; h++) cnt[h] <= CNT_W'(1);
    end else begin
      status_q <= status_next;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (free_we && free_waddr == '0) seg0_wr[heap_q] <= 1'b1;
      case (state)
        ffha_pkg::S_CLEAR: clr_i <= clr_i + 1'b1;
        ffha_pkg::S_IDLE: begin
          if (in_acc) begin
            cmd_q      <= s_tuser;
            heap_q     <= heap_in;
            need_q     <= need_sum[16:ffha_pkg::UNIT_SHIFT];
            addr_q     <= s_tdata[38:20];
            n_q        <= cnt[heap_in];
            rd_i       <= '0;
            pv         <= 1'b0;
            slot_found <= 1'b0;
            hit        <= 1'b0;
            res_q      <= '0;
          end
        end
        ffha_pkg::S_ASCAN: begin
          pv <= issue_all;
          if (issue_all) begin
            rd_i <= rd_i + 1'b1;
            ck_i <= rd_i[SEG_W-1:0];
          end
          if (pv) begin
            if (!slot_found && !used_rd.valid) begin
              slot_found <= 1'b1;
              slot_q     <= ck_i;
            end
            if (!hit && CNT_W'(ck_i) < n_q && free_eff.units >= need_q) begin
              hit   <= 1'b1;
              p_q   <= CNT_W'(ck_i);
              nxt_q <= free_eff;
            end
          end
        end
        ffha_pkg::S_ADO: begin
          sh_dn  <= 1'b1;
          sh_i   <= p_q;
          sh_lim <= n_q;
          fin_wr <= 1'b0;
          pend   <= 1'b0;
          if (slot_found && hit) begin
            res_q <= AW'({nxt_q.start, {ffha_pkg::UNIT_SHIFT{1'b0}}}) +
                     AW'(ffha_pkg::HEADER_BYTES);
            if (whole) cnt[heap_q] <= n_q - 1'b1;
          end
        end
        ffha_pkg::S_USCAN: begin
          pv <= issue_all;
          if (issue_all) begin
            rd_i <= rd_i + 1'b1;
            ck_i <= rd_i[SEG_W-1:0];
          end
          if (pv && !slot_found && u_match) begin
            slot_found <= 1'b1;
            slot_q     <= ck_i;
            st_q       <= used_rd.start;
            un_q       <= used_rd.units;
          end
          if (state_next == ffha_pkg::S_FSCAN) begin
            rd_i <= '0;
            pv   <= 1'b0;
          end
        end
        ffha_pkg::S_FSCAN: begin
          pv <= issue_n;
          if (issue_n) begin
            rd_i <= rd_i + 1'b1;
            ck_i <= rd_i[SEG_W-1:0];
          end
          if (pv && !hit) begin
            if (free_eff.start >= st_q) begin
              hit   <= 1'b1;
              p_q   <= CNT_W'(ck_i);
              nxt_q <= free_eff;
            end else begin
              prev_q <= free_eff;
            end
          end
          if (!issue_n && !pv && !hit) p_q <= n_q;
        end
        ffha_pkg::S_FDO: begin
          pend <= 1'b0;
          if (mprev && mnext) begin
            sh_dn       <= 1'b1;
            sh_i        <= p_q;
            sh_lim      <= n_q;
            fin_wr      <= 1'b0;
            cnt[heap_q] <= n_q - 1'b1;
          end else begin
            sh_dn  <= 1'b0;
            sh_i   <= n_q;
            sh_lim <= p_q;
            fin_wr <= 1'b1;
            if (!mprev && !mnext && n_q < CNT_W'(MAX_SEGMENTS)) cnt[heap_q] <= n_q + 1'b1;
          end
        end
        ffha_pkg::S_SHIFT: begin
          pend <= rd_go;
          if (rd_go) begin
            pend_dst <= sh_i[SEG_W-1:0];
            sh_i     <= sh_dn ? sh_i + 1'b1 : sh_i - 1'b1;
          end
        end
        ffha_pkg::S_DONE: begin
          m_tvalid <= 1'b1;
          m_tdata  <= {2'b00, status_q,
                       (status_q == ffha_pkg::ST_OK && cmd_q == ffha_pkg::CMD_ALLOC) ?
                       res_q : {AW{1'b0}}};
        end
        default: ;
      endcase
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while busy");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[21:19] != ffha_pkg::ST_OK |-> m_tdata[18:0] == '0)
    else $error("failed request returned an address");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt[heap_q] <= CNT_W'(MAX_SEGMENTS))
    else $error("free segment count overflow");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    state == ffha_pkg::S_CLEAR |-> !m_tvalid && !s_tready)
    else $error("activity during clearing pass");

endmodule

### tb/sv/first_fit_heap_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_tb
// Drives allocate and free requests on the allocator, mostly under random
// idling on both stream sides, predicts every result from a behavioral
// copy of the heaps and checks each result in order.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_tb;
  import ffha_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  first_fit_heap_allocator DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct {
    logic [ADDR_W-1:0] addr;
    status_t           st;
  } grant_t;

  grant_t pending_grants[$];
  int     mismatches = 0;
  bit     sender_gaps = 1'b1;
  bit     receiver_gaps = 1'b1;
  int     hold_off = 0;

  logic [1:0] m_present;
  logic [7:0] m_current;
  int  seg_start [HEAP_COUNT][MAX_SEGMENTS];
  int  seg_units [HEAP_COUNT][MAX_SEGMENTS];
  int  seg_count [HEAP_COUNT];
  int  blk_start [HEAP_COUNT][MAX_SEGMENTS];
  int  blk_units [HEAP_COUNT][MAX_SEGMENTS];
  bit  blk_live  [HEAP_COUNT][MAX_SEGMENTS];
  int  live_heap[$];
  int  live_addr[$];

  function automatic int select_heap(logic ar, logic [2:0] hi);
    int h;
    if (!m_present[ar]) return -1;
    h = hi[2] ? int'(m_current[2*ar +: 2]) : int'(hi);
    if (h >= HEAPS_PER_ARENA) return -1;
    return int'(ar) * HEAPS_PER_ARENA + h;
  endfunction

  function automatic status_t allocate_block(int h, logic [15:0] rq, output int addr);
    int slot, need, sg, left;
    slot = -1;
    for (int i = 0; i < MAX_SEGMENTS; i++)
      if (!blk_live[h][i] && slot < 0) slot = i;
    if (slot < 0) return ST_FULL;
    need = (int'(rq) + HEADER_BYTES + UNIT_BYTES - 1) / UNIT_BYTES;
    sg = -1;
    for (int i = 0; i < seg_count[h]; i++)
      if (sg < 0 && seg_units[h][i] >= need) sg = i;
    if (sg < 0) return ST_NOFIT;
    left = seg_units[h][sg] - need;
    blk_start[h][slot] = seg_start[h][sg];
    blk_live[h][slot] = 1'b1;
    if (left < MIN_KEEP) begin
      blk_units[h][slot] = seg_units[h][sg];
      for (int i = sg; i + 1 < seg_count[h]; i++) begin
        seg_start[h][i] = seg_start[h][i+1];
        seg_units[h][i] = seg_units[h][i+1];
      end
      seg_count[h]--;
    end else begin
      blk_units[h][slot] = need;
      seg_start[h][sg] += need;
      seg_units[h][sg] = left;
    end
    addr = (blk_start[h][slot] * UNIT_BYTES + HEADER_BYTES) & 'h7FFFF;
    return ST_OK;
  endfunction

  function automatic status_t release_block(int h, logic [18:0] ba);
    int slot, st, un, p, n;
    bit mp, mn;
    slot = -1;
    n = seg_count[h];
    for (int i = 0; i < MAX_SEGMENTS; i++)
      if (slot < 0 && blk_live[h][i] && blk_start[h][i] * UNIT_BYTES + HEADER_BYTES == int'(ba))
        slot = i;
    if (slot < 0) return ST_UNKNOWN;
    st = blk_start[h][slot];
    un = blk_units[h][slot];
    p = n;
    for (int i = n - 1; i >= 0; i--)
      if (seg_start[h][i] >= st) p = i;
    mn = (p < n) && (st + un == seg_start[h][p]);
    mp = (p > 0) && (seg_start[h][p-1] + seg_units[h][p-1] == st);
    if (mp && mn) begin
      seg_units[h][p-1] += un + seg_units[h][p];
      for (int i = p; i + 1 < n; i++) begin
        seg_start[h][i] = seg_start[h][i+1];
        seg_units[h][i] = seg_units[h][i+1];
      end
      seg_count[h] = n - 1;
    end else if (mp) begin
      seg_units[h][p-1] += un;
    end else if (mn) begin
      seg_start[h][p] = st;
      seg_units[h][p] += un;
    end else begin
      if (n >= MAX_SEGMENTS) return ST_FULL;
      for (int i = n; i > p; i--) begin
        seg_start[h][i] = seg_start[h][i-1];
        seg_units[h][i] = seg_units[h][i-1];
      end
      seg_start[h][p] = st;
      seg_units[h][p] = un;
      seg_count[h] = n + 1;
    end
    blk_live[h][slot] = 1'b0;
    return ST_OK;
  endfunction

  function automatic void predict_grant(logic cmd, logic ar, logic [2:0] hi,
                                        logic [15:0] rq, logic [18:0] ba,
                                        output grant_t g);
    int h, addr;
    addr = 0;
    h = select_heap(ar, hi);
    if (h < 0) g.st = ST_ARENA;
    else if (cmd == CMD_ALLOC) g.st = allocate_block(h, rq, addr);
    else g.st = release_block(h, ba);
    if (g.st != ST_OK) addr = 0;
    g.addr = addr[18:0];
    if (g.st == ST_OK && cmd == CMD_ALLOC) begin
      live_heap.push_back(h);
      live_addr.push_back(addr);
    end else if (g.st == ST_OK) begin
      for (int i = 0; i < live_addr.size(); i++)
        if (live_heap[i] == h && live_addr[i] == int'(ba)) begin
          live_heap.delete(i);
          live_addr.delete(i);
          break;
        end
    end
  endfunction

  task automatic send_request(input logic cmd, input logic ar, input logic [2:0] hi,
                              input logic [15:0] rq, input logic [18:0] ba,
                              output grant_t g);
    bit ok;
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {1'b0, ba, rq, hi, ar};
    do begin
      @(negedge clk);
      ok = s_tready;
      @(posedge clk);
    end while (!ok);
    predict_grant(cmd, ar, hi, rq, ba, g);
    pending_grants.push_back(g);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [7:0] val);
    bit ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 1'b0;
    if (idx == CFG_ARENA_PRESENT) m_present = val[1:0];
    else m_current = val;
  endtask

  task automatic configure(input logic [7:0] present, input logic [7:0] current);
    drain();
    write_register(CFG_ARENA_PRESENT, present);
    write_register(CFG_CURRENT_HEAPS, current);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        hold_off--;
        m_tready <= 1'b0;
      end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(posedge clk);
        @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
      @(negedge clk);
      if (m_tvalid && m_tready) begin
        if (pending_grants.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_tdata);
          mismatches++;
        end else begin
          grant_t g;
          g = pending_grants.pop_front();
          if (m_tdata[18:0] !== g.addr || m_tdata[21:19] !== g.st) begin
            $display("%0t: expected addr %h status %0d, actual addr %h status %0d",
                     $time, g.addr, g.st, m_tdata[18:0], m_tdata[21:19]);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic test_directed();
    grant_t g, b;
    send_request(CMD_ALLOC, 1'b0, 3'd0, 16'd0, '0, g);
    send_request(CMD_FREE, 1'b1, 3'd7, 16'd0, 19'h7FFFF, g);
    configure(8'd3, 8'h00);
    send_request(CMD_ALLOC, 1'b0, 3'd0, 16'd0, '0, g);
    send_request(CMD_ALLOC, 1'b0, 3'd1, 16'hFFFF, '0, g);
    send_request(CMD_ALLOC, 1'b0, 3'd1, 16'd65504, '0, b);
    send_request(CMD_ALLOC, 1'b0, 3'd1, 16'd1, '0, g);
    send_request(CMD_FREE, 1'b0, 3'd1, 16'hFFFF, 19'h7FFFF, g);
    send_request(CMD_FREE, 1'b0, 3'd1, 16'd0, b.addr, g);
    send_request(CMD_FREE, 1'b0, 3'd1, 16'd0, b.addr, g);
    send_request(CMD_ALLOC, 1'b1, 3'b111, 16'd100, '0, b);
    send_request(CMD_ALLOC, 1'b1, 3'b100, 16'd31, '0, g);
    send_request(CMD_ALLOC, 1'b1, 3'd3, 16'd65472, '0, g);
    send_request(CMD_FREE, 1'b1, 3'd2, 16'd0, b.addr, g);
    send_request(CMD_FREE, 1'b1, 3'b110, 16'd0, b.addr, g);
    send_request(CMD_ALLOC, 1'b0, 3'd0, 16'd64, '0, g);
    send_request(CMD_ALLOC, 1'b0, 3'd0, 16'd32, '0, b);
    send_request(CMD_ALLOC, 1'b0, 3'd0, 16'd0, '0, g);
    send_request(CMD_FREE, 1'b0, 3'd0, 16'd0, b.addr, g);
    send_request(CMD_ALLOC, 1'b0, 3'd0, 16'd40, '0, g);
  endtask

  task automatic test_used_table_full();
    grant_t g;
    for (int k = 0; k < MAX_SEGMENTS + 1; k++)
      send_request(CMD_ALLOC, 1'b1, 3'd2, 16'd0, '0, g);
    for (int i = live_addr.size() - 1; i >= 0; i--)
      if (live_heap[i] == 6) send_request(CMD_FREE, 1'b1, 3'd2, 16'd0, live_addr[i], g);
  endtask

  task automatic test_free_table_full();
    grant_t g;
    int grp[$];
    for (int s = 2; s <= 9; s++) begin
      grp.delete();
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
        send_request(CMD_ALLOC, 1'b0, 3'd3, 16'((s - 1) * 32), '0, g);
        if (g.st != ST_OK) break;
        grp.push_back(g.addr);
      end
      for (int k = 0; k + 1 < grp.size(); k += 2)
        send_request(CMD_FREE, 1'b0, 3'd3, 16'd0, grp[k], g);
    end
    for (int i = live_addr.size() - 1; i >= 0; i--)
      if (live_heap[i] == 3) send_request(CMD_FREE, 1'b0, 3'd3, 16'd0, live_addr[i], g);
  endtask

  task automatic random_requests(input int count);
    grant_t g;
    int pick;
    logic [2:0] hi;
    for (int n = 0; n < count; n++) begin
      hi = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 9) < 6) begin
        send_request(CMD_ALLOC, 1'($urandom), hi,
                     ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000)),
                     19'($urandom), g);
      end else if (live_addr.size() != 0 && $urandom_range(0, 9) < 8) begin
        pick = $urandom_range(0, live_addr.size() - 1);
        send_request(CMD_FREE, 1'(live_heap[pick] / HEAPS_PER_ARENA),
                     3'(live_heap[pick] % HEAPS_PER_ARENA), 16'($urandom),
                     live_addr[pick], g);
      end else begin
        send_request(CMD_FREE, 1'($urandom), hi, 16'($urandom), 19'($urandom), g);
      end
    end
  endtask

  task automatic test_pressure();
    drain();
    hold_off = 400;
    random_requests(12);
  endtask

  initial begin
    m_present = '0;
    m_current = '0;
    for (int h = 0; h < HEAP_COUNT; h++) begin
      seg_start[h][0] = h * HEAP_UNITS;
      seg_units[h][0] = HEAP_UNITS;
      seg_count[h] = 1;
      for (int i = 0; i < MAX_SEGMENTS; i++) blk_live[h][i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_used_table_full();
    test_free_table_full();
    configure(8'd3, 8'hE4);
    random_requests(120);
    test_pressure();
    configure(8'd1, 8'hFF);
    random_requests(60);
    configure(8'd2, 8'h00);
    random_requests(60);
    configure(8'd3, 8'h1B);
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    random_requests(160);
    drain();
    if (mismatches == 0 && pending_grants.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
